// File: rtl/core/tlse_pkg.sv
`timescale 1ns / 1ps
// tlse_pkg: widths, request and status codes, payload structs and the
// controller/datapath command and status structs for the stabilizer engine.
// No dependencies.
package tlse_pkg;

  // Lattice geometry
  localparam int MAX_SIDE    = 64;
  localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
  localparam int COORD_W     = $clog2(MAX_SIDE);
  localparam int STORE_DEPTH = 2 * MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SITE_W      = ADDR_W - 1;
  localparam int SQ_W        = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int DIV_W       = SITE_W;
  localparam int DCNT_W      = $clog2(COORD_W);
  localparam int FLIP_STEPS  = 4;
  localparam int STEP_W      = $clog2(FLIP_STEPS);

  // Payload field widths
  localparam int TYPE_W = 2;
  localparam int IDX_W  = 13;
  localparam int NODE_W = 12;

  localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
  localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(4);

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_FLIP_VERTEX    = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_FLIP_PLAQUETTE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_WRITE_SPIN     = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_QUERY_SPIN     = 2'd3;

  // Status codes
  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [IDX_W-1:0]  target_index;
    logic              spin_value;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic              spin_down;
    logic [NODE_W-1:0] vertex_first;
    logic [NODE_W-1:0] vertex_second;
    logic [NODE_W-1:0] plaquette_first;
    logic [NODE_W-1:0] plaquette_second;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic div_start;
    logic load_neigh;
    logic clear;
    logic mem_rd;
    logic flip_wr;
    logic spin_wr;
    logic step_inc;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic oor;
    logic is_flip;
    logic is_write;
    logic div_done;
    logic clr_last;
    logic step_last;
  } sts_t;

endpackage

// File: rtl/core/tlse_div.sv
`timescale 1ns / 1ps
// tlse_div: restoring divider, one quotient bit per cycle, splits a site
// index into row and column. Depends on tlse_pkg.
module tlse_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tlse_pkg::SITE_W-1:0]  dividend,
  input  logic [tlse_pkg::SIDE_W-1:0]  divisor,
  output logic                         done,
  output logic [tlse_pkg::COORD_W-1:0] quotient,
  output logic [tlse_pkg::COORD_W-1:0] remainder
);

  logic                          busy;
  logic [tlse_pkg::DCNT_W-1:0]   cnt;
  logic [tlse_pkg::DIV_W-1:0]    rem;
  logic [tlse_pkg::DIV_W-1:0]    dsh;
  logic [tlse_pkg::COORD_W-1:0]  quo;
  logic                          ge;

  assign ge = (rem >= dsh);

  // Sequence the steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= tlse_pkg::DCNT_W'(tlse_pkg::COORD_W - 1);
      end else if (busy) begin
        cnt <= cnt - tlse_pkg::DCNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Subtract the shifted divisor where it fits, shift in one quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= tlse_pkg::DIV_W'(dividend);
      dsh <= tlse_pkg::DIV_W'(divisor) << (tlse_pkg::COORD_W - 1);
      quo <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quo <= {quo[tlse_pkg::COORD_W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem[tlse_pkg::COORD_W-1:0];

endmodule

// File: rtl/core/tlse_dpath.sv
`timescale 1ns / 1ps
// tlse_dpath: side register, request register, divider, neighbor sites,
// spin memory and result register. Depends on tlse_pkg and tlse_div.
module tlse_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [tlse_pkg::SIDE_W-1:0] cfg_data,
  input  tlse_pkg::in_item_t          in_data,
  input  tlse_pkg::cmd_t              cmd,
  output tlse_pkg::sts_t              sts,
  output tlse_pkg::out_item_t         out_data
);

  logic [tlse_pkg::SIDE_W-1:0]   side;
  logic [tlse_pkg::SQ_W-1:0]     side_sq;
  logic [tlse_pkg::SIDE_W-1:0]   side_sat;
  logic [2*tlse_pkg::SIDE_W-1:0] sq_prod;

  tlse_pkg::in_item_t            item;
  logic                          is_flip;
  logic                          is_write;
  logic                          oor;
  logic [tlse_pkg::SITE_W-1:0]   site;
  logic                          orient;

  logic                          div_done;
  logic [tlse_pkg::COORD_W-1:0]  x;
  logic [tlse_pkg::COORD_W-1:0]  y;

  logic [tlse_pkg::SQ_W-1:0]     s_w;
  logic [tlse_pkg::SQ_W-1:0]     l_w;
  logic [tlse_pkg::SQ_W-1:0]     x_w;
  logic [tlse_pkg::SQ_W-1:0]     y_w;
  logic [tlse_pkg::SQ_W-1:0]     one_w;
  logic [tlse_pkg::SQ_W-1:0]     xm_w;
  logic [tlse_pkg::SQ_W-1:0]     xp_w;
  logic [tlse_pkg::SQ_W-1:0]     ym_w;
  logic [tlse_pkg::SQ_W-1:0]     yp_w;
  logic [tlse_pkg::SITE_W-1:0]   nb_xm;
  logic [tlse_pkg::SITE_W-1:0]   nb_xp;
  logic [tlse_pkg::SITE_W-1:0]   nb_ym;
  logic [tlse_pkg::SITE_W-1:0]   nb_yp;

  logic [tlse_pkg::STEP_W-1:0]   step;
  logic [tlse_pkg::ADDR_W-1:0]   clr_addr;
  logic [tlse_pkg::ADDR_W-1:0]   flip_addr;
  logic [tlse_pkg::ADDR_W-1:0]   mem_addr;
  logic                          mem_we;
  logic                          mem_wdata;
  logic                          mem [tlse_pkg::STORE_DEPTH];
  logic                          rd_bit;

  tlse_pkg::out_item_t           res;

  // Saturate the side into range and square it on a write
  always_comb begin
    if (cfg_data < tlse_pkg::SIDE_MIN) begin
      side_sat = tlse_pkg::SIDE_MIN;
    end else if (cfg_data > tlse_pkg::SIDE_MAX) begin
      side_sat = tlse_pkg::SIDE_MAX;
    end else begin
      side_sat = cfg_data;
    end
  end

  assign sq_prod = side_sat * side_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      side    <= tlse_pkg::SIDE_RESET;
      side_sq <= tlse_pkg::SQ_W'(tlse_pkg::SIDE_RESET * tlse_pkg::SIDE_RESET);
    end else if (cfg_valid) begin
      side    <= side_sat;
      side_sq <= sq_prod[tlse_pkg::SQ_W-1:0];
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
  end

  // Classify the request and check its index
  assign is_flip  = (item.req_type == tlse_pkg::REQ_FLIP_VERTEX) ||
                    (item.req_type == tlse_pkg::REQ_FLIP_PLAQUETTE);
  assign is_write = (item.req_type == tlse_pkg::REQ_WRITE_SPIN);
  assign orient   = item.target_index[0];

  always_comb begin
    if (is_flip) begin
      oor  = (item.target_index >= side_sq);
      site = item.target_index[tlse_pkg::SITE_W-1:0];
    end else begin
      oor  = ({1'b0, item.target_index} >= {side_sq, 1'b0});
      site = item.target_index[tlse_pkg::IDX_W-1:1];
    end
  end

  // Split the site into row and column
  tlse_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (site),
    .divisor   (side),
    .done      (div_done),
    .quotient  (x),
    .remainder (y)
  );

  // Neighbor sites with wraparound
  assign s_w   = tlse_pkg::SQ_W'(site);
  assign l_w   = tlse_pkg::SQ_W'(side);
  assign x_w   = tlse_pkg::SQ_W'(x);
  assign y_w   = tlse_pkg::SQ_W'(y);
  assign one_w = tlse_pkg::SQ_W'(1);

  assign xm_w = (x == '0) ? side_sq - l_w + y_w : s_w - l_w;
  assign xp_w = (x_w == l_w - one_w) ? y_w : s_w + l_w;
  assign ym_w = (y == '0) ? s_w + l_w - one_w : s_w - one_w;
  assign yp_w = (y_w == l_w - one_w) ? s_w - l_w + one_w : s_w + one_w;

  always_ff @(posedge clk) begin
    if (cmd.load_neigh) begin
      nb_xm <= xm_w[tlse_pkg::SITE_W-1:0];
      nb_xp <= xp_w[tlse_pkg::SITE_W-1:0];
      nb_ym <= ym_w[tlse_pkg::SITE_W-1:0];
      nb_yp <= yp_w[tlse_pkg::SITE_W-1:0];
    end
  end

  // Step through the four spins of a star or a plaquette
  always_ff @(posedge clk) begin
    if (rst || cmd.load_item) begin
      step <= '0;
    end else if (cmd.step_inc) begin
      step <= step + tlse_pkg::STEP_W'(1);
    end
  end

  always_comb begin
    if (item.req_type == tlse_pkg::REQ_FLIP_VERTEX) begin
      case (step)
        2'd0:    flip_addr = {nb_ym, 1'b1};
        2'd1:    flip_addr = {site, 1'b0};
        2'd2:    flip_addr = {site, 1'b1};
        default: flip_addr = {nb_xp, 1'b0};
      endcase
    end else begin
      case (step)
        2'd0:    flip_addr = {site, 1'b0};
        2'd1:    flip_addr = {nb_xm, 1'b1};
        2'd2:    flip_addr = {nb_yp, 1'b0};
        default: flip_addr = {site, 1'b1};
      endcase
    end
  end

  // Sweep the store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + tlse_pkg::ADDR_W'(1);
    end
  end

  // Spin memory: one address per cycle, registered read
  always_comb begin
    if (cmd.clear) begin
      mem_addr = clr_addr;
    end else if (is_flip) begin
      mem_addr = flip_addr;
    end else begin
      mem_addr = item.target_index[tlse_pkg::ADDR_W-1:0];
    end
  end

  assign mem_we    = cmd.clear | cmd.flip_wr | cmd.spin_wr;
  assign mem_wdata = cmd.clear ? 1'b0 : (cmd.flip_wr ? ~rd_bit : item.spin_value);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      rd_bit <= mem[mem_addr];
    end
  end

  // Build the result
  always_comb begin
    res        = '0;
    res.status = oor ? tlse_pkg::STATUS_RANGE : tlse_pkg::STATUS_DONE;
    if (!oor && !is_flip) begin
      res.spin_down = is_write ? item.spin_value : rd_bit;
      if (!orient) begin
        res.vertex_first     = nb_xm;
        res.vertex_second    = site;
        res.plaquette_first  = nb_ym;
        res.plaquette_second = site;
      end else begin
        res.vertex_first     = site;
        res.vertex_second    = nb_yp;
        res.plaquette_first  = site;
        res.plaquette_second = nb_xp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= res;
    end
  end

  always_comb begin
    sts           = '0;
    sts.oor       = oor;
    sts.is_flip   = is_flip;
    sts.is_write  = is_write;
    sts.div_done  = div_done;
    sts.clr_last  = (clr_addr == tlse_pkg::ADDR_W'(tlse_pkg::STORE_DEPTH - 1));
    sts.step_last = (step == tlse_pkg::STEP_W'(tlse_pkg::FLIP_STEPS - 1));
  end

`ifndef ASSERT_OFF
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.flip_wr, cmd.spin_wr}))
    else $error("more than one memory write source");

  a_flip_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.flip_wr |-> $past(cmd.mem_rd))
    else $error("flip write without a read in the cycle before");

  a_column_in_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (tlse_pkg::SIDE_W'(y) < side))
    else $error("column not below the lattice side");
`endif

endmodule

// File: rtl/core/tlse_ctrl.sv
`timescale 1ns / 1ps
// tlse_ctrl: sequencer for the stabilizer engine and owner of the output
// valid flag. Depends on tlse_pkg.
module tlse_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output tlse_pkg::cmd_t cmd,
  input  tlse_pkg::sts_t sts
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_CHECK   = 10'b00_0000_0100,
    S_DIV     = 10'b00_0000_1000,
    S_NEIGH   = 10'b00_0001_0000,
    S_FLIP_RD = 10'b00_0010_0000,
    S_FLIP_WR = 10'b00_0100_0000,
    S_SPIN_WR = 10'b00_1000_0000,
    S_SPIN_RD = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.oor) begin
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_NEIGH;
        end
      end
      S_NEIGH: begin
        cmd.load_neigh = 1'b1;
        if (sts.is_flip) begin
          state_next = S_FLIP_RD;
        end else if (sts.is_write) begin
          state_next = S_SPIN_WR;
        end else begin
          state_next = S_SPIN_RD;
        end
      end
      S_FLIP_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_FLIP_WR;
      end
      S_FLIP_WR: begin
        cmd.flip_wr  = 1'b1;
        cmd.step_inc = 1'b1;
        state_next   = sts.step_last ? S_DONE : S_FLIP_RD;
      end
      S_SPIN_WR: begin
        cmd.spin_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_SPIN_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Hold the result until the receiver takes the transaction
  assign out_valid_next = cmd.load_out | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result register loaded while a stalled result waits");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_CHECK))
    else $error("accepted transaction did not start a range check");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && out_valid && out_stall) |=> (state == S_DONE))
    else $error("finished result dropped while the output is stalled");
`endif

endmodule

// File: rtl/core/toric_lattice_stabilizer_engine_unit.sv
`timescale 1ns / 1ps
// Toric code stabilizer engine: top level joining the sequencer and the
// datapath. Depends on tlse_pkg, tlse_ctrl and tlse_dpath.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one request per
//   transaction: flip a vertex star, flip a plaquette, write a spin or
//   query a spin. Output channel (out_valid / out_stall / out_data): one
//   result per request, in request order.
//   Configuration channel (cfg_valid / cfg_ready / cfg_data): sets the
//   lattice side, saturated to 2..64; always ready, write it only while
//   no request is in flight.
//   Sequence after acceptance: an out-of-range index goes from the range
//   check straight to the result; otherwise the division yields six
//   quotient bits, then done, the neighbor sites are loaded, and a spin
//   write or query makes one memory access, while a flip does four
//   read-modify-write passes on the single-port spin memory. The next
//   request is accepted the cycle after a result is registered.
//   Reset: the side returns to 4, and the spin memory is swept to all
//   spins up, during which in_stall stays high.
//   A stalled output holds its result; one more request may finish and
//   then waits inside until the output register frees up.
module toric_lattice_stabilizer_engine_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tlse_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tlse_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tlse_pkg::SIDE_W-1:0] cfg_data
);

  tlse_pkg::cmd_t cmd;
  tlse_pkg::sts_t sts;

  // Side register takes a write on any cycle
  assign cfg_ready = 1'b1;

  tlse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  tlse_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_toric_lattice_stabilizer_engine_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the toric lattice stabilizer engine: a queue-fed
// driver, a monitor with its own lattice predictor, and a phased side sweep.
// Depends on tlse_pkg and toric_lattice_stabilizer_engine_unit.
module tb_toric_lattice_stabilizer_engine_unit;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 132;
  localparam int CALM_PHASE  = 7;
  localparam int SETTLE      = 25;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  tlse_pkg::in_item_t          in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  tlse_pkg::out_item_t         out_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [tlse_pkg::SIDE_W-1:0] cfg_data = '0;

  // Predictor state: spin lattice and side in use
  bit [tlse_pkg::STORE_DEPTH-1:0] spin_map = '0;
  int unsigned                    lat_side = 4;

  tlse_pkg::in_item_t  request_queue[$];
  tlse_pkg::out_item_t expected_results[$];
  int                  mismatch_count = 0;
  int                  cycle_count = 0;
  bit                  calm = 1'b0;

  // Config values swept phase by phase; out-of-range ones saturate
  int unsigned side_plan[PHASES] = '{0, 127, 3, 1, 65, 64, 2, 5, 8, 6, 3, 4};

  toric_lattice_stabilizer_engine_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void toggle_spin(int unsigned x, int unsigned y, int unsigned o);
    spin_map[2 * (x * lat_side + y) + o] ^= 1'b1;
  endfunction

  // Apply one request to the lattice and return the result it should produce
  function automatic tlse_pkg::out_item_t apply_lattice_request(tlse_pkg::in_item_t req);
    tlse_pkg::out_item_t res;
    int unsigned side, sites, idx, site, o, x, y, xm, xp, ym, yp;
    int unsigned v1, v2, p1, p2;
    res   = '0;
    side  = lat_side;
    sites = side * side;
    idx   = 32'(req.target_index);
    if (req.req_type == tlse_pkg::REQ_FLIP_VERTEX ||
        req.req_type == tlse_pkg::REQ_FLIP_PLAQUETTE) begin
      if (idx >= sites) begin
        res.status = tlse_pkg::STATUS_RANGE;
      end else begin
        x  = idx / side;
        y  = idx % side;
        xm = (x == 0) ? side - 1 : x - 1;
        xp = (x == side - 1) ? 0 : x + 1;
        ym = (y == 0) ? side - 1 : y - 1;
        yp = (y == side - 1) ? 0 : y + 1;
        if (req.req_type == tlse_pkg::REQ_FLIP_VERTEX) begin
          toggle_spin(x, ym, 1);
          toggle_spin(x, y, 0);
          toggle_spin(x, y, 1);
          toggle_spin(xp, y, 0);
        end else begin
          toggle_spin(x, y, 0);
          toggle_spin(xm, y, 1);
          toggle_spin(x, yp, 0);
          toggle_spin(x, y, 1);
        end
      end
    end else if (idx >= 2 * sites) begin
      res.status = tlse_pkg::STATUS_RANGE;
    end else begin
      if (req.req_type == tlse_pkg::REQ_WRITE_SPIN) spin_map[idx] = req.spin_value;
      site = idx >> 1;
      o    = idx & 1;
      x    = site / side;
      y    = site % side;
      xm   = (x == 0) ? side - 1 : x - 1;
      xp   = (x == side - 1) ? 0 : x + 1;
      ym   = (y == 0) ? side - 1 : y - 1;
      yp   = (y == side - 1) ? 0 : y + 1;
      if (o == 0) begin
        v1 = xm * side + y;
        v2 = x * side + y;
        p1 = x * side + ym;
        p2 = x * side + y;
      end else begin
        v1 = x * side + y;
        v2 = x * side + yp;
        p1 = x * side + y;
        p2 = xp * side + y;
      end
      res.status           = tlse_pkg::STATUS_DONE;
      res.spin_down        = spin_map[idx];
      res.vertex_first     = tlse_pkg::NODE_W'(v1);
      res.vertex_second    = tlse_pkg::NODE_W'(v2);
      res.plaquette_first  = tlse_pkg::NODE_W'(p1);
      res.plaquette_second = tlse_pkg::NODE_W'(p2);
    end
    return res;
  endfunction

  function automatic tlse_pkg::in_item_t make_req(logic [tlse_pkg::TYPE_W-1:0] kind,
                                                  int unsigned idx, logic val);
    tlse_pkg::in_item_t req;
    req.req_type     = kind;
    req.target_index = tlse_pkg::IDX_W'(idx);
    req.spin_value   = val;
    return req;
  endfunction

  // Mostly in-range requests for the current side, some anywhere in the index space
  function automatic tlse_pkg::in_item_t random_request();
    tlse_pkg::in_item_t req;
    int unsigned        pick, sites;
    sites = lat_side * lat_side;
    pick  = $urandom_range(0, 99);
    if (pick < 30)      req.req_type = tlse_pkg::REQ_FLIP_VERTEX;
    else if (pick < 50) req.req_type = tlse_pkg::REQ_FLIP_PLAQUETTE;
    else if (pick < 70) req.req_type = tlse_pkg::REQ_WRITE_SPIN;
    else                req.req_type = tlse_pkg::REQ_QUERY_SPIN;
    req.spin_value = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 15)
      req.target_index = tlse_pkg::IDX_W'($urandom_range(0, 8191));
    else if (req.req_type == tlse_pkg::REQ_FLIP_VERTEX ||
             req.req_type == tlse_pkg::REQ_FLIP_PLAQUETTE)
      req.target_index = tlse_pkg::IDX_W'($urandom_range(0, sites - 1));
    else
      req.target_index = tlse_pkg::IDX_W'($urandom_range(0, 2 * sites - 1));
    return req;
  endfunction

  // Hold until the driver is empty and every expected result has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Driver: offer the next request once the current transaction is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (request_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
        in_valid <= 1'b1;
        in_data  <= request_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output backpressure
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else     out_stall <= !calm && ($urandom_range(0, 99) < 32);
  end

  // Monitor: track config, check results, predict accepted requests
  always @(posedge clk) begin
    tlse_pkg::out_item_t exp_res;
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        lat_side = 32'((cfg_data < tlse_pkg::SIDE_MIN) ? tlse_pkg::SIDE_MIN :
                       (cfg_data > tlse_pkg::SIDE_MAX) ? tlse_pkg::SIDE_MAX : cfg_data);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction %p", out_data);
          mismatch_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_data.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_data.status);
            mismatch_count++;
          end
          if (out_data.spin_down !== exp_res.spin_down) begin
            $error("spin_down: expected %0d, got %0d", exp_res.spin_down, out_data.spin_down);
            mismatch_count++;
          end
          if (out_data.vertex_first !== exp_res.vertex_first) begin
            $error("vertex_first: expected %0d, got %0d",
                   exp_res.vertex_first, out_data.vertex_first);
            mismatch_count++;
          end
          if (out_data.vertex_second !== exp_res.vertex_second) begin
            $error("vertex_second: expected %0d, got %0d",
                   exp_res.vertex_second, out_data.vertex_second);
            mismatch_count++;
          end
          if (out_data.plaquette_first !== exp_res.plaquette_first) begin
            $error("plaquette_first: expected %0d, got %0d",
                   exp_res.plaquette_first, out_data.plaquette_first);
            mismatch_count++;
          end
          if (out_data.plaquette_second !== exp_res.plaquette_second) begin
            $error("plaquette_second: expected %0d, got %0d",
                   exp_res.plaquette_second, out_data.plaquette_second);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(apply_lattice_request(in_data));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus: reset, directed requests at side 4, then one random phase per side
  initial begin
    int p, n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fresh lattice, wraparound corners, last in-range index, out-of-range indexes
    request_queue.push_back(make_req(tlse_pkg::REQ_QUERY_SPIN, 0, 1'b0));
    request_queue.push_back(make_req(tlse_pkg::REQ_WRITE_SPIN, 0, 1'b1));
    request_queue.push_back(make_req(tlse_pkg::REQ_QUERY_SPIN, 0, 1'b0));
    request_queue.push_back(make_req(tlse_pkg::REQ_FLIP_VERTEX, 0, 1'b0));
    request_queue.push_back(make_req(tlse_pkg::REQ_FLIP_PLAQUETTE, 15, 1'b1));
    request_queue.push_back(make_req(tlse_pkg::REQ_FLIP_VERTEX, 15, 1'b0));
    request_queue.push_back(make_req(tlse_pkg::REQ_FLIP_PLAQUETTE, 0, 1'b0));
    request_queue.push_back(make_req(tlse_pkg::REQ_FLIP_VERTEX, 12, 1'b0));
    request_queue.push_back(make_req(tlse_pkg::REQ_QUERY_SPIN, 1, 1'b0));
    request_queue.push_back(make_req(tlse_pkg::REQ_QUERY_SPIN, 7, 1'b0));
    request_queue.push_back(make_req(tlse_pkg::REQ_QUERY_SPIN, 31, 1'b0));
    request_queue.push_back(make_req(tlse_pkg::REQ_WRITE_SPIN, 31, 1'b1));
    request_queue.push_back(make_req(tlse_pkg::REQ_WRITE_SPIN, 30, 1'b0));
    request_queue.push_back(make_req(tlse_pkg::REQ_FLIP_VERTEX, 16, 1'b0));
    request_queue.push_back(make_req(tlse_pkg::REQ_FLIP_PLAQUETTE, 16, 1'b1));
    request_queue.push_back(make_req(tlse_pkg::REQ_QUERY_SPIN, 32, 1'b0));
    request_queue.push_back(make_req(tlse_pkg::REQ_WRITE_SPIN, 32, 1'b1));
    request_queue.push_back(make_req(tlse_pkg::REQ_QUERY_SPIN, 8191, 1'b1));
    request_queue.push_back(make_req(tlse_pkg::REQ_FLIP_VERTEX, 8191, 1'b1));
    request_queue.push_back(make_req(tlse_pkg::REQ_QUERY_SPIN, 31, 1'b0));

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      // Write the side while nothing is in flight
      @(posedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= tlse_pkg::SIDE_W'(side_plan[p]);
      do @(posedge clk);
      while (!cfg_ready);
      cfg_valid <= 1'b0;
      @(negedge clk);
      calm = (p == CALM_PHASE);
      // At the largest side, hit the top of the index space
      if (p == 1) begin
        request_queue.push_back(make_req(tlse_pkg::REQ_WRITE_SPIN, 8191, 1'b1));
        request_queue.push_back(make_req(tlse_pkg::REQ_FLIP_VERTEX, 4095, 1'b0));
        request_queue.push_back(make_req(tlse_pkg::REQ_FLIP_PLAQUETTE, 4095, 1'b1));
        request_queue.push_back(make_req(tlse_pkg::REQ_QUERY_SPIN, 8191, 1'b0));
      end
      for (n = 0; n < PHASE_ITEMS; n++)
        request_queue.push_back(random_request());
    end

    wait_drained();
    calm = 1'b0;
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: toric_lattice_stabilizer_engine_unit.f
rtl/core/tlse_pkg.sv
rtl/core/tlse_div.sv
rtl/core/tlse_dpath.sv
rtl/core/tlse_ctrl.sv
rtl/core/toric_lattice_stabilizer_engine_unit.sv
tb/tb_toric_lattice_stabilizer_engine_unit.sv
